FILE: rtl/lhhm_pkg.sv
// Types and constants shared by the link heartbeat health monitor.
// No dependencies; used by lhhm_engine and link_heartbeat_health_monitor_core.
package lhhm_pkg;

    localparam int NOW_W = 48;
    localparam int SEQ_W = 32;
    localparam int BUF_W = 32;
    localparam int THR_W = 24;
    localparam int MAX_RES = 3;

    localparam logic [1:0] OP_OPEN = 2'd0;
    localparam logic [1:0] OP_MSG  = 2'd1;
    localparam logic [1:0] OP_POLL = 2'd2;

    localparam logic [1:0] EV_PING      = 2'd0;
    localparam logic [1:0] EV_PONG      = 2'd1;
    localparam logic [1:0] EV_HEALTH    = 2'd2;
    localparam logic [1:0] EV_RECONNECT = 2'd3;

    localparam logic [1:0] H_HEALTHY  = 2'd0;
    localparam logic [1:0] H_UNSTABLE = 2'd1;
    localparam logic [1:0] H_LOST     = 2'd2;

    localparam logic [1:0] CFG_PING_INTERVAL = 2'd0;
    localparam logic [1:0] CFG_UNSTABLE      = 2'd1;
    localparam logic [1:0] CFG_LOST          = 2'd2;
    localparam logic [1:0] CFG_RECONNECT     = 2'd3;

    localparam logic [THR_W-1:0] PING_INTERVAL_RST = 24'd10000;
    localparam logic [THR_W-1:0] UNSTABLE_RST      = 24'd60000;
    localparam logic [THR_W-1:0] LOST_RST          = 24'd120000;

    typedef struct packed {
        logic [1:0]       op;
        logic [NOW_W-1:0] now_ms;
        logic             shutting_down;
        logic             channel_up;
        logic             send_accepted;
        logic             is_text;
        logic             is_heartbeat_msg;
        logic             is_ping_action;
        logic [BUF_W-1:0] buffered_total;
    } in_item_t;

    typedef struct packed {
        logic [1:0]       event_kind;
        logic [SEQ_W-1:0] sequence_res;
        logic             delivered;
        logic [1:0]       health;
        logic             health_moved;
        logic             last;
    } res_item_t;

    typedef struct packed {
        logic [THR_W-1:0] ping_interval_ms;
        logic [THR_W-1:0] unstable_after_ms;
        logic [THR_W-1:0] lost_after_ms;
        logic             reconnect_allowed;
    } cfg_t;

    typedef struct packed {
        res_item_t [MAX_RES-1:0] slot;
        logic [1:0]              count;
    } batch_t;

endpackage

FILE: rtl/lhhm_engine.sv
// Monitor state registers and the single-pass event logic that builds one
// batch of up to three results. Depends on lhhm_pkg.
module lhhm_engine #(
    parameter int TIME_BITS = 48
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                go,
    input  lhhm_pkg::in_item_t  item,
    input  lhhm_pkg::cfg_t      cfg,
    output lhhm_pkg::batch_t    batch
);

    logic [TIME_BITS-1:0]      li_reg, li_next;
    logic [TIME_BITS-1:0]      lo_reg, lo_next;
    logic [TIME_BITS-1:0]      lp_reg, lp_next;
    logic [lhhm_pkg::BUF_W-1:0] prior_reg, prior_next;
    logic                      neg_reg, neg_next;
    logic [1:0]                health_reg, health_next;
    logic [lhhm_pkg::SEQ_W-1:0] count_reg, count_next;

    logic [TIME_BITS-1:0]      now_t;
    logic [TIME_BITS-1:0]      li_eff, lo_eff, lp_fill, lp_eff;
    logic [TIME_BITS-1:0]      el_out, silence, el_prog;
    logic [lhhm_pkg::SEQ_W-1:0] seq_inc;
    logic                      e_send, e_hc, e_rc, moved;
    logic [1:0]                send_kind, h_hc, h_mid;
    lhhm_pkg::res_item_t       r_send, r_hc, r_rc;

    assign now_t   = TIME_BITS'(item.now_ms);
    assign li_eff  = (li_reg == '0) ? now_t : li_reg;
    assign lo_eff  = (lo_reg == '0) ? now_t : lo_reg;
    assign lp_fill = (lp_reg == '0) ? now_t : lp_reg;
    assign lp_eff  = (item.buffered_total < prior_reg) ? now_t : lp_fill;
    assign el_out  = now_t - lo_eff;
    assign silence = now_t - li_eff;
    assign el_prog = now_t - lp_eff;
    assign seq_inc = count_reg + 32'd1;

    always_comb
    begin
        li_next     = li_reg;
        lo_next     = lo_reg;
        lp_next     = lp_reg;
        prior_next  = prior_reg;
        neg_next    = neg_reg;
        count_next  = count_reg;
        e_send      = 1'b0;
        e_hc        = 1'b0;
        e_rc        = 1'b0;
        moved       = 1'b0;
        send_kind   = lhhm_pkg::EV_PING;
        h_hc        = health_reg;
        h_mid       = health_reg;
        if (!item.shutting_down)
        begin
            case (item.op)
                lhhm_pkg::OP_OPEN:
                begin
                    li_next    = now_t;
                    lo_next    = now_t;
                    lp_next    = now_t;
                    prior_next = item.buffered_total;
                    neg_next   = 1'b0;
                    e_send     = item.channel_up;
                end
                lhhm_pkg::OP_MSG:
                begin
                    li_next   = now_t;
                    send_kind = lhhm_pkg::EV_PONG;
                    if (item.is_text && item.is_heartbeat_msg)
                    begin
                        neg_next = 1'b1;
                        e_send   = item.is_ping_action && item.channel_up;
                    end
                end
                lhhm_pkg::OP_POLL:
                begin
                    li_next    = li_eff;
                    lo_next    = lo_eff;
                    lp_next    = lp_eff;
                    prior_next = item.buffered_total;
                    e_send     = item.channel_up &&
                                 (el_out >= TIME_BITS'(cfg.ping_interval_ms));
                    if (neg_reg)
                    begin
                        if (silence < TIME_BITS'(cfg.unstable_after_ms))
                        begin
                            e_hc = (health_reg != lhhm_pkg::H_HEALTHY);
                            h_hc = lhhm_pkg::H_HEALTHY;
                        end
                        else
                        begin
                            if (health_reg == lhhm_pkg::H_HEALTHY)
                            begin
                                e_hc  = 1'b1;
                                h_hc  = lhhm_pkg::H_UNSTABLE;
                                h_mid = lhhm_pkg::H_UNSTABLE;
                            end
                            if ((silence >= TIME_BITS'(cfg.lost_after_ms)) &&
                                (el_prog >= TIME_BITS'(cfg.lost_after_ms)) &&
                                cfg.reconnect_allowed)
                            begin
                                e_rc  = 1'b1;
                                moved = (h_mid != lhhm_pkg::H_LOST);
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
            if (e_send)
            begin
                count_next = seq_inc;
                if (item.send_accepted)
                    lo_next = now_t;
            end
        end
    end

    assign health_next = e_rc ? lhhm_pkg::H_LOST : (e_hc ? h_hc : health_reg);

    always_comb
    begin
        r_send.event_kind   = send_kind;
        r_send.sequence_res = seq_inc;
        r_send.delivered    = item.send_accepted;
        r_send.health       = health_reg;
        r_send.health_moved = 1'b0;
        r_send.last         = !(e_hc || e_rc);

        r_hc.event_kind     = lhhm_pkg::EV_HEALTH;
        r_hc.sequence_res   = '0;
        r_hc.delivered      = 1'b0;
        r_hc.health         = h_hc;
        r_hc.health_moved   = 1'b0;
        r_hc.last           = !e_rc;

        r_rc.event_kind     = lhhm_pkg::EV_RECONNECT;
        r_rc.sequence_res   = '0;
        r_rc.delivered      = 1'b0;
        r_rc.health         = lhhm_pkg::H_LOST;
        r_rc.health_moved   = moved;
        r_rc.last           = 1'b1;

        // pack present results toward slot 0, in emission order
        batch.slot[0] = e_send ? r_send : (e_hc ? r_hc : r_rc);
        batch.slot[1] = e_send ? (e_hc ? r_hc : r_rc) : r_rc;
        batch.slot[2] = r_rc;
        batch.count   = 2'({1'b0, e_send} + {1'b0, e_hc} + {1'b0, e_rc});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            li_reg     <= '0;
            lo_reg     <= '0;
            lp_reg     <= '0;
            prior_reg  <= '0;
            neg_reg    <= 1'b0;
            health_reg <= lhhm_pkg::H_HEALTHY;
            count_reg  <= '0;
        end
        else if (go)
        begin
            li_reg     <= li_next;
            lo_reg     <= lo_next;
            lp_reg     <= lp_next;
            prior_reg  <= prior_next;
            neg_reg    <= neg_next;
            health_reg <= health_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: rtl/link_heartbeat_health_monitor_core.sv
// Top level of the link heartbeat health monitor: input register, config
// registers and the result shift buffer. Depends on lhhm_pkg, lhhm_engine.
//
// Usage:
//   in_*  : one event request per accepted cycle (in_valid high, in_stall low).
//   out_* : result requests, at most three per event, the final one with
//           last set; an event may give no result at all.
//   cfg_* : register writes (index 0..3); cfg_ready is always high. Write
//           only while no event is in flight.
// Flow: an accepted event waits in the input register and is evaluated when
//   the result buffer can load; its results are then offered from the buffer.
// Throughput: one event per cycle while each event gives at most one result
//   and out_stall is low; an event with more results holds the engine until
//   its results drain, since the result buffer drains one entry per cycle.
// Reset: all monitor state clears (health healthy, sequence zero, times
//   unset), registers take their defaults, no results are pending.
// Stall: out_stall holds the head result; the buffer and input register fill
//   and in_stall then rises until results drain.
module link_heartbeat_health_monitor_core #(
    parameter int TIME_BITS = 48
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  lhhm_pkg::in_item_t          in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output lhhm_pkg::res_item_t         out_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [1:0]                  cfg_index,
    input  logic [lhhm_pkg::THR_W-1:0]  cfg_data
);

    lhhm_pkg::in_item_t                      in_reg;
    logic                                    in_vld_reg;
    lhhm_pkg::cfg_t                          cfg_reg;
    lhhm_pkg::res_item_t [lhhm_pkg::MAX_RES-1:0] slot_reg;
    logic [1:0]                              cnt_reg;
    lhhm_pkg::batch_t                        batch;
    logic                                    take, load_ok, go;

    assign take      = out_valid && !out_stall;
    assign load_ok   = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && take);
    assign go        = in_vld_reg && load_ok;
    assign in_stall  = in_vld_reg && !load_ok;
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = slot_reg[0];
    assign cfg_ready = 1'b1;

    lhhm_engine #(
        .TIME_BITS (TIME_BITS)
    ) u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (go),
        .item  (in_reg),
        .cfg   (cfg_reg),
        .batch (batch)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (in_valid && !in_stall)
            in_vld_reg <= 1'b1;
        else if (go)
            in_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            in_reg <= in_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ping_interval_ms  <= lhhm_pkg::PING_INTERVAL_RST;
            cfg_reg.unstable_after_ms <= lhhm_pkg::UNSTABLE_RST;
            cfg_reg.lost_after_ms     <= lhhm_pkg::LOST_RST;
            cfg_reg.reconnect_allowed <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                lhhm_pkg::CFG_PING_INTERVAL: cfg_reg.ping_interval_ms  <= cfg_data;
                lhhm_pkg::CFG_UNSTABLE:      cfg_reg.unstable_after_ms <= cfg_data;
                lhhm_pkg::CFG_LOST:          cfg_reg.lost_after_ms     <= cfg_data;
                lhhm_pkg::CFG_RECONNECT:     cfg_reg.reconnect_allowed <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else if (go)
            cnt_reg <= batch.count;
        else if (take)
            cnt_reg <= cnt_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (go)
            slot_reg <= batch.slot;
        else if (take)
        begin
            slot_reg[0] <= slot_reg[1];
            slot_reg[1] <= slot_reg[2];
        end
    end

    a_last_on_final: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd1) |-> slot_reg[0].last)
        else $error("final pending result lacks last");

    a_no_early_last: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg > 2'd1) |-> !slot_reg[0].last)
        else $error("last set before final result");

    a_nonhb_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ((out_data.event_kind == lhhm_pkg::EV_HEALTH) ||
                       (out_data.event_kind == lhhm_pkg::EV_RECONNECT)))
        |-> ((out_data.sequence_res == '0) && !out_data.delivered))
        else $error("status result carries heartbeat fields");

    a_moved_only_rc: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.event_kind != lhhm_pkg::EV_RECONNECT))
        |-> !out_data.health_moved)
        else $error("health_moved on non-reconnect result");

endmodule
